[rtl/vpt_pkg.sv]
package vpt_pkg;

    // item modes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_BYTE    = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    // result status codes
    localparam logic [2:0] STS_GOOD       = 3'd0;
    localparam logic [2:0] STS_BAD_HEADER = 3'd1;
    localparam logic [2:0] STS_BAD_ADDR   = 3'd2;
    localparam logic [2:0] STS_TOO_LONG   = 3'd3;
    localparam logic [2:0] STS_CHECKSUM   = 3'd4;
    localparam logic [2:0] STS_TIMEOUT    = 3'd5;

    // frame bytes and commands
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;
    localparam logic [7:0] ADDR_BYTE   = 8'h11;
    localparam logic [7:0] CMD_INFO    = 8'h29;
    localparam logic [7:0] CMD_BLOCK   = 8'h2A;

    // configuration registers
    localparam int         CFG_INDEX_W = 2;
    localparam int         CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_A    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRACK_B    = 2'd2;
    localparam logic [7:0]  MAX_LENGTH_RST = 8'd30;
    localparam logic [15:0] TRACK_A_RST    = 16'd5;
    localparam logic [15:0] TRACK_B_RST    = 16'd6;

    // byte position counter saturates at its top value
    localparam int         POS_W   = 6;
    localparam logic [POS_W-1:0] POS_MAX = 6'd63;

    // packet bytes that are read back: command, count/x, y, id
    localparam int SLOT_CMD   = 0;
    localparam int SLOT_B5    = 1;
    localparam int SLOT_B6    = 2;
    localparam int SLOT_B7    = 3;
    localparam int SLOT_B8    = 4;
    localparam int SLOT_B13   = 5;
    localparam int SLOT_B14   = 6;
    localparam int CAP_SLOTS  = 7;
    localparam logic [POS_W-1:0] CAP_POS [CAP_SLOTS] =
        '{6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd13, 6'd14};

    typedef enum logic [5:0] {
        STEP_HUNT = 6'b000001,
        STEP_HDR2 = 6'b000010,
        STEP_ADDR = 6'b000100,
        STEP_LEN  = 6'b001000,
        STEP_BODY = 6'b010000,
        STEP_SUM  = 6'b100000
    } step_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_INFO   = 3'b010,
        PH_BLOCKS = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command;
        logic        update_done;
        logic        update_ok;
        logic        found_a;
        logic [15:0] coord_x_a;
        logic [15:0] coord_y_a;
        logic        found_b;
        logic [15:0] coord_x_b;
        logic [15:0] coord_y_b;
    } out_item_t;

    // end of a packet as seen by the frame parser
    typedef struct packed {
        logic        done;
        logic [2:0]  status;
        logic [7:0]  cmd;
        logic [15:0] count;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] id;
    } frame_evt_t;

endpackage

[rtl/vpt_frame.sv]
module vpt_frame #(
    parameter int CAPTURE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [1:0]        mode,
    input  logic [7:0]        rx_byte,
    input  logic              active,
    input  logic [7:0]        max_length,
    output vpt_pkg::frame_evt_t evt
);
    import vpt_pkg::*;

    step_t            step_reg, step_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       sum_reg, sum_next;
    logic             keep;
    logic             clear;
    logic             evt_done;
    logic [2:0]       evt_status;
    logic [7:0]       cap_view [CAP_SLOTS];

    always_comb
    begin
        step_next  = step_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        keep       = 1'b0;
        clear      = 1'b0;
        evt_done   = 1'b0;
        evt_status = STS_GOOD;
        if (fire)
        begin
            if (mode == MODE_START)
            begin
                clear = 1'b1;
            end
            else if (active && mode == MODE_TIMEOUT)
            begin
                clear      = 1'b1;
                evt_done   = 1'b1;
                evt_status = STS_TIMEOUT;
            end
            else if (active && mode == MODE_BYTE)
            begin
                unique case (step_reg)
                    STEP_HUNT:
                    begin
                        if (rx_byte == SYNC_FIRST)
                        begin
                            keep      = 1'b1;
                            step_next = STEP_HDR2;
                        end
                    end
                    STEP_HDR2:
                    begin
                        if (rx_byte != SYNC_SECOND)
                        begin
                            clear      = 1'b1;
                            evt_done   = 1'b1;
                            evt_status = STS_BAD_HEADER;
                        end
                        else
                        begin
                            keep      = 1'b1;
                            step_next = STEP_ADDR;
                        end
                    end
                    STEP_ADDR:
                    begin
                        if (rx_byte != ADDR_BYTE)
                        begin
                            clear      = 1'b1;
                            evt_done   = 1'b1;
                            evt_status = STS_BAD_ADDR;
                        end
                        else
                        begin
                            keep      = 1'b1;
                            step_next = STEP_LEN;
                        end
                    end
                    STEP_LEN:
                    begin
                        keep = 1'b1;
                        if (rx_byte > max_length)
                        begin
                            clear      = 1'b1;
                            evt_done   = 1'b1;
                            evt_status = STS_TOO_LONG;
                        end
                        else
                        begin
                            len_next  = rx_byte;
                            step_next = STEP_BODY;
                        end
                    end
                    STEP_BODY:
                    begin
                        keep = 1'b1;
                        if (len_reg == 8'd0)
                            step_next = STEP_SUM;
                        else
                            len_next = len_reg - 8'd1;
                    end
                    STEP_SUM:
                    begin
                        // checksum byte is kept even when it mismatches
                        keep       = 1'b1;
                        clear      = 1'b1;
                        evt_done   = 1'b1;
                        evt_status = (rx_byte != sum_reg) ? STS_CHECKSUM : STS_GOOD;
                    end
                    default:
                    begin
                        clear = 1'b1;
                    end
                endcase
            end
        end
        if (keep)
        begin
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;
            sum_next = sum_reg + rx_byte;
        end
        if (clear)
        begin
            step_next = STEP_HUNT;
            pos_next  = '0;
            len_next  = '0;
            sum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_HUNT;
            pos_reg  <= '0;
            len_reg  <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            sum_reg  <= sum_next;
        end
    end

    // only the packet bytes that are read back are stored; the byte
    // written in this cycle is forwarded so the checksum byte counts
    for (genvar k = 0; k < CAP_SLOTS; k++)
    begin : g_cap
        if (CAP_POS[k] < CAPTURE_DEPTH)
        begin : g_kept
            logic [7:0] byte_reg;
            logic       wr;
            assign wr = keep && (pos_reg == CAP_POS[k]);
            always_ff @(posedge clk)
            begin
                if (wr)
                    byte_reg <= rx_byte;
            end
            assign cap_view[k] = wr ? rx_byte : byte_reg;
        end
        else
        begin : g_dropped
            assign cap_view[k] = 8'd0;
        end
    end

    assign evt.done   = evt_done;
    assign evt.status = evt_status;
    assign evt.cmd    = cap_view[SLOT_CMD];
    assign evt.count  = {cap_view[SLOT_B6], cap_view[SLOT_B5]};
    assign evt.x      = {cap_view[SLOT_B6], cap_view[SLOT_B5]};
    assign evt.y      = {cap_view[SLOT_B8], cap_view[SLOT_B7]};
    assign evt.id     = {cap_view[SLOT_B14], cap_view[SLOT_B13]};

endmodule

[rtl/vpt_track.sv]
module vpt_track (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [1:0]          mode,
    input  vpt_pkg::frame_evt_t evt,
    input  logic [15:0]         track_id_a,
    input  logic [15:0]         track_id_b,
    output logic                active,
    output logic                res_valid,
    output vpt_pkg::out_item_t  res
);
    import vpt_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] blocks_reg, blocks_next;
    logic        found_a_reg, found_a_next;
    logic        found_b_reg, found_b_next;
    logic [15:0] xa_reg, xa_next, ya_reg, ya_next;
    logic [15:0] xb_reg, xb_next, yb_reg, yb_next;
    logic        done;
    logic        ok;
    logic [7:0]  cmd;
    logic        first_bad;

    assign active = (phase_reg != PH_IDLE);

    always_comb
    begin
        phase_next   = phase_reg;
        blocks_next  = blocks_reg;
        found_a_next = found_a_reg;
        found_b_next = found_b_reg;
        xa_next      = xa_reg;
        ya_next      = ya_reg;
        xb_next      = xb_reg;
        yb_next      = yb_reg;
        res_valid    = 1'b0;
        done         = 1'b0;
        ok           = 1'b0;
        cmd          = 8'd0;
        first_bad    = 1'b0;
        if (fire && mode == MODE_START)
        begin
            found_a_next = 1'b0;
            found_b_next = 1'b0;
            phase_next   = PH_INFO;
        end
        else if (evt.done)
        begin
            res_valid = 1'b1;
            if (evt.status != STS_GOOD)
            begin
                done       = 1'b1;
                ok         = (phase_reg == PH_BLOCKS);
                phase_next = PH_IDLE;
            end
            else
            begin
                cmd = evt.cmd;
                if (phase_reg == PH_INFO)
                begin
                    if (evt.cmd != CMD_INFO)
                    begin
                        first_bad  = 1'b1;
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        blocks_next = evt.count;
                        phase_next  = PH_BLOCKS;
                    end
                end
                else
                begin
                    blocks_next = blocks_reg - 16'd1;
                    if (evt.cmd == CMD_BLOCK)
                    begin
                        if (evt.id == track_id_a)
                        begin
                            found_a_next = 1'b1;
                            xa_next      = evt.x;
                            ya_next      = evt.y;
                        end
                        if (evt.id == track_id_b)
                        begin
                            found_b_next = 1'b1;
                            xb_next      = evt.x;
                            yb_next      = evt.y;
                        end
                    end
                end
                if (!first_bad && blocks_next == 16'd0)
                begin
                    done       = 1'b1;
                    ok         = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_comb
    begin
        res.status      = evt.status;
        res.command     = cmd;
        res.update_done = done;
        res.update_ok   = ok;
        res.found_a     = found_a_next;
        res.coord_x_a   = xa_next;
        res.coord_y_a   = ya_next;
        res.found_b     = found_b_next;
        res.coord_x_b   = xb_next;
        res.coord_y_b   = yb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            blocks_reg  <= '0;
            found_a_reg <= 1'b0;
            found_b_reg <= 1'b0;
            xa_reg      <= '0;
            ya_reg      <= '0;
            xb_reg      <= '0;
            yb_reg      <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            blocks_reg  <= blocks_next;
            found_a_reg <= found_a_next;
            found_b_reg <= found_b_next;
            xa_reg      <= xa_next;
            ya_reg      <= ya_next;
            xb_reg      <= xb_next;
            yb_reg      <= yb_next;
        end
    end

endmodule

[rtl/vision_packet_parser_tracker.sv]
// Serial packet parser and object tracker. Each input request carries one
// event of a byte stream: start of an update, a received byte, or a byte
// wait that timed out. Packets (55 AA 11, length, length+1 command/data
// bytes, 8-bit additive checksum) are parsed; the first packet of an update
// must be an info packet giving a block count, and block packets whose id
// matches track_id_a or track_id_b update that slot's found flag and x/y.
// Every finished packet, bad packet or timeout inside an update returns one
// result request; starts, idle bytes and bytes before a header return none.
// Flow: an accepted request is held in the input register and handled by
// the parser and tracker once the result register is free or draining; its
// result (if any) is then loaded into the result register, which drives
// out_item. Throughput is one request per clock while results are taken;
// a held result stalls the input only once the input register
// is also full. Configuration writes are taken in any cycle (cfg_ready is
// always high) and should be done while no update is in flight.
module vision_packet_parser_tracker #(
    parameter int CAPTURE_DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  vpt_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output vpt_pkg::out_item_t                    out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vpt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [vpt_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import vpt_pkg::*;

    // input register
    logic       hold_valid_reg;
    in_item_t   hold_item_reg;
    // result register
    logic       out_valid_reg;
    out_item_t  out_item_reg;
    // configuration
    logic [7:0]  max_length_reg;
    logic [15:0] track_a_reg;
    logic [15:0] track_b_reg;

    logic        step_fire;
    logic        active;
    logic        res_valid;
    out_item_t   res;
    frame_evt_t  evt;

    // the held request is processed once the result slot is free or draining
    assign step_fire = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !hold_valid_reg || step_fire;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            hold_valid_reg <= 1'b1;
        else if (step_fire)
            hold_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            hold_item_reg <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_fire && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && res_valid)
            out_item_reg <= res;
    end

    // register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
            track_a_reg    <= TRACK_A_RST;
            track_b_reg    <= TRACK_B_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_LENGTH: max_length_reg <= cfg_data[7:0];
                CFG_TRACK_A:    track_a_reg    <= cfg_data;
                CFG_TRACK_B:    track_b_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // byte-level framing, length check, checksum and byte capture
    vpt_frame #(
        .CAPTURE_DEPTH(CAPTURE_DEPTH)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (step_fire),
        .mode      (hold_item_reg.mode),
        .rx_byte   (hold_item_reg.rx_byte),
        .active    (active),
        .max_length(max_length_reg),
        .evt       (evt)
    );

    // update sequencing, block count and tracked object slots
    vpt_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (step_fire),
        .mode      (hold_item_reg.mode),
        .evt       (evt),
        .track_id_a(track_a_reg),
        .track_id_b(track_b_reg),
        .active    (active),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

[rtl/vpt_checker.sv]
module vpt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input vpt_pkg::out_item_t              out_item
);
    import vpt_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // error results end the update and carry no command
    a_err_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != STS_GOOD |->
            out_item.update_done && out_item.command == 8'd0)
        else $error("error result does not end update");

    // success is reported only on the result that ends the update
    a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.update_ok |-> out_item.update_done)
        else $error("update_ok without update_done");

    // no result, good, bad or timed out, reports a status past the timeout code
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status <= STS_TIMEOUT)
        else $error("status code out of range");

endmodule

bind vision_packet_parser_tracker vpt_checker u_vpt_checker (.*);
